// ----- hw/rtl/ukvt_pkg.sv -----
// Package for the unordered key/value table: action and status codes,
// controller state type and the command/status structs between ctrl and datapath.
// No dependencies.
`default_nettype none

package ukvt_pkg;

   typedef logic [1:0] action_code_type;
   typedef logic [1:0] status_code_type;

   localparam action_code_type ACT_LOOKUP = 2'd0;
   localparam action_code_type ACT_ASSIGN = 2'd1;
   localparam action_code_type ACT_ERASE  = 2'd2;

   localparam status_code_type STATUS_OK     = 2'd0;
   localparam status_code_type STATUS_ABSENT = 2'd1;
   localparam status_code_type STATUS_FULL   = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SCAN    = 5'b00010,
      S_FETCH   = 5'b00100,
      S_MOVE    = 5'b01000,
      S_RESPOND = 5'b10000
   } state_type;

   typedef struct packed {
      logic start;       // latch request beat, restart search
      logic scan;        // issue table reads, compare
      logic finish;      // conclude search, apply assign, capture result
      logic fetch_last;  // read last entry for erase
      logic move;        // write last entry into freed slot
      logic load_rsp;    // load output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic hit;
      logic is_erase;
      logic rsp_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ukvt_channels.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on ukvt_pkg.
`default_nettype none

interface ukvt_req_if #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   ukvt_pkg::action_code_type    action;
   logic [KEY_BITS-1:0]          key;
   logic [VALUE_BITS-1:0]        new_value;

   modport source (output valid, output action, output key, output new_value, input ready);
   modport sink   (input valid, input action, input key, input new_value, output ready);
endinterface

interface ukvt_rsp_if #(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 5
);
   logic                         valid;
   logic                         ready;
   ukvt_pkg::status_code_type    status;
   logic [VALUE_BITS-1:0]        found_value;
   logic [COUNT_BITS-1:0]        entry_count;

   modport source (output valid, output status, output found_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found_value, input entry_count,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ukvt_ctrl.sv -----
// Controller state machine for the key/value table: sequences search,
// erase move and response load. Depends on ukvt_pkg.
`default_nettype none

module ukvt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ukvt_pkg::ctrl_status_type  stat,
   output ukvt_pkg::ctrl_cmd_type     cmd
);
   import ukvt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               cmd.finish = 1'b1;
               state_in   = (stat.is_erase && stat.hit) ? S_FETCH : S_RESPOND;
            end
         end
         S_FETCH: begin
            cmd.fetch_last = 1'b1;
            state_in       = S_MOVE;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ukvt_datapath.sv -----
// Datapath for the key/value table: key and value memories, request and
// search registers, entry count and output register. Depends on ukvt_pkg.
`default_nettype none

module ukvt_datapath #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ukvt_pkg::ctrl_cmd_type     cmd,
   output ukvt_pkg::ctrl_status_type  stat,
   input  ukvt_pkg::action_code_type  req_action,
   input  logic [KEY_BITS-1:0]        req_key,
   input  logic [VALUE_BITS-1:0]      req_new_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ukvt_pkg::status_code_type  rsp_status,
   output logic [VALUE_BITS-1:0]      rsp_found_value,
   output logic [COUNT_BITS-1:0]      rsp_entry_count
);
   import ukvt_pkg::*;

   localparam int ADDR_BITS = $clog2(DEPTH);

   logic [KEY_BITS-1:0]   key_mem [DEPTH];
   logic [VALUE_BITS-1:0] val_mem [DEPTH];

   action_code_type       action_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic                  pipe_valid_ff, pipe_valid_in;
   logic [ADDR_BITS-1:0]  pipe_idx_ff;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [ADDR_BITS-1:0]  pos_ff, pos_in;
   status_code_type       res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_found_ff, res_found_in;
   logic                  rsp_valid_ff;
   status_code_type       rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_found_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic                  more, issue, hit, is_nop, rsp_free;
   logic                  rd_en, wr_en;
   logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_val;
   logic [COUNT_BITS-1:0] last_idx;

   assign more     = (idx_ff < count_ff);
   assign issue    = cmd.scan && more;
   // read data at stage after issue belongs to pipe_idx_ff
   assign hit      = pipe_valid_ff && (key_rd_ff == key_ff);
   assign is_nop   = (action_ff != ACT_LOOKUP) && (action_ff != ACT_ASSIGN) &&
                     (action_ff != ACT_ERASE);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign last_idx = count_ff - COUNT_BITS'(1);

   assign stat.scan_done = is_nop || hit || (!pipe_valid_ff && !more);
   assign stat.hit       = hit;
   assign stat.is_erase  = (action_ff == ACT_ERASE);
   assign stat.rsp_free  = rsp_free;

   assign rd_en   = issue || cmd.fetch_last;
   assign rd_addr = cmd.fetch_last ? last_idx[ADDR_BITS-1:0] : idx_ff[ADDR_BITS-1:0];

   assign idx_in        = issue ? idx_ff + COUNT_BITS'(1) : idx_ff;
   assign pipe_valid_in = issue;

   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = pipe_idx_ff;
      wr_key        = key_ff;
      wr_val        = value_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      if (cmd.finish) begin
         res_status_in = STATUS_OK;
         res_found_in  = '0;
         case (action_ff)
            ACT_LOOKUP: begin
               if (hit) begin
                  res_found_in = val_rd_ff;
               end else begin
                  res_status_in = STATUS_ABSENT;
               end
            end
            ACT_ASSIGN: begin
               if (hit) begin
                  wr_en = 1'b1;
               end else if (count_ff < COUNT_BITS'(DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_BITS-1:0];
                  count_in = count_ff + COUNT_BITS'(1);
               end else begin
                  res_status_in = STATUS_FULL;
               end
            end
            ACT_ERASE: begin
               if (hit) begin
                  pos_in = pipe_idx_ff;
               end else begin
                  res_status_in = STATUS_ABSENT;
               end
            end
            default: begin
               res_status_in = STATUS_OK;
            end
         endcase
      end else if (cmd.move) begin
         wr_en    = 1'b1;
         wr_addr  = pos_ff;
         wr_key   = key_rd_ff;
         wr_val   = val_rd_ff;
         count_in = last_idx;
      end
   end

   // memories: one registered read port, one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         val_rd_ff <= val_mem[rd_addr];
      end
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         action_ff <= req_action;
         key_ff    <= req_key;
         value_ff  <= req_new_value;
      end
      pipe_idx_ff   <= idx_ff[ADDR_BITS-1:0];
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.start) begin
            idx_ff        <= '0;
            pipe_valid_ff <= 1'b0;
         end else begin
            idx_ff        <= idx_in;
            pipe_valid_ff <= pipe_valid_in;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("entry count above table depth");

   a_move_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.move |=> count_ff == $past(count_ff) - COUNT_BITS'(1))
      else $error("erase move did not shrink count by one");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("output register overwritten while beat pending");

endmodule

`default_nettype wire

// ----- hw/rtl/unordered_key_value_table_top.sv -----
// Unordered key/value table, linear search over a packed table of DEPTH pairs.
// A request is searched entry by entry until a hit or the end of the table; an unused action
// ends the search at once, and an erase that hits adds the fetch-last and move states.
// One request in flight; the next beat is accepted the cycle after the response is loaded,
// and the search issues one memory read per cycle.
// Reset (synchronous): count and handshake state cleared; table contents are kept.
`default_nettype none

module unordered_key_value_table_top #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   ukvt_req_if.sink       req_if,
   ukvt_rsp_if.source     rsp_if
);
   import ukvt_pkg::*;

   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   ctrl_cmd_type    cmd;
   ctrl_status_type stat;
   logic            req_ready;

   ukvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_if.ready = req_ready;

   ukvt_datapath #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_if.action),
      .req_key         (req_if.key),
      .req_new_value   (req_if.new_value),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_status      (rsp_if.status),
      .rsp_found_value (rsp_if.found_value),
      .rsp_entry_count (rsp_if.entry_count)
   );

endmodule

`default_nettype wire
